### sv/color_space_converter_assert.svh
// Assertion macros for the color space converter checker.
`ifndef COLOR_SPACE_CONVERTER_ASSERT_SVH
`define COLOR_SPACE_CONVERTER_ASSERT_SVH

// Implication checked only outside reset.
`define CSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked also during reset.
`define CSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/csc_pkg.sv
package csc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int FRAC     = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef enum logic [1:0] {
        MODE_RGB_YUV = 2'd0,
        MODE_RGB_YIQ = 2'd1,
        MODE_YUV_RGB = 2'd2,
        MODE_YIQ_RGB = 2'd3
    } t_mode;

    localparam logic [PADDR_W-1:0] ADDR_MODE = 3'd0;

    // [mode][output row][input column], signed Q16
    localparam logic signed [COEF_W-1:0] COEF [4][3][3] = '{
        '{ '{ 18'sd19595,  18'sd38470,   18'sd7471 },
           '{-18'sd11058, -18'sd21710,  18'sd32768 },
           '{ 18'sd32768, -18'sd27439,  -18'sd5329 } },
        '{ '{ 18'sd19595,  18'sd38470,   18'sd7471 },
           '{ 18'sd39059, -18'sd18022, -18'sd21037 },
           '{ 18'sd13894, -18'sd34275,  18'sd20382 } },
        '{ '{ 18'sd65536,       18'sd0,  18'sd91881 },
           '{ 18'sd65536, -18'sd22553, -18'sd46802 },
           '{ 18'sd65536, 18'sd116130,       18'sd0 } },
        '{ '{ 18'sd65536,  18'sd62652,  18'sd40698 },
           '{ 18'sd65536, -18'sd17826, -18'sd42402 },
           '{ 18'sd65536, -18'sd72483, 18'sd111608 } }
    };

endpackage

### sv/csc_mult.sv
module csc_mult import csc_pkg::*; #(
    parameter int SB = 16,
    parameter int PW = SB + 2 + COEF_W
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  t_mode                i_mode,
    input  logic [SB-1:0]        i_samp [3],
    output logic signed [PW-1:0] o_prod [3][3],
    output logic                 o_chroma_off
);

    localparam int TW = SB + 2;
    localparam logic signed [TW-1:0] MAXV_T = TW'({SB{1'b1}});

    logic                 centred;
    logic signed [TW-1:0] t [3];
    logic signed [PW-1:0] r_prod [3][3];
    logic                 r_chroma_off;

    assign centred = (i_mode == MODE_YUV_RGB) || (i_mode == MODE_YIQ_RGB);

    // samples enter as 2*s; chroma inputs re-centred around zero in the YUV/YIQ to RGB modes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t[i] = $signed({1'b0, i_samp[i], 1'b0});
            if (centred && i > 0) begin
                t[i] = t[i] - MAXV_T;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_prod[k][i] <= PW'(t[i]) * PW'(COEF[i_mode][k][i]);
                end
            end
            r_chroma_off <= !centred;
        end
    end

    assign o_prod       = r_prod;
    assign o_chroma_off = r_chroma_off;

endmodule

### sv/csc_round.sv
module csc_round import csc_pkg::*; #(
    parameter int SB = 16,
    parameter int PW = SB + 2 + COEF_W
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic signed [PW-1:0] i_prod [3][3],
    input  logic                 i_chroma_off,
    output logic [SAMPLE_W-1:0]  o_res [3]
);

    localparam int AW  = PW + 2;
    localparam int SHW = AW - FRAC - 1;
    localparam logic signed [AW-1:0] HALF_OFF = AW'({{SB{1'b1}}, {FRAC{1'b0}}});
    localparam logic signed [AW-1:0] RND      = AW'(2 ** FRAC);
    localparam logic [SHW-1:0]       MAXV_SH  = SHW'({SB{1'b1}});

    logic signed [AW-1:0] acc [3];
    logic signed [AW-1:0] biased [3];
    logic [SHW-1:0]       shifted [3];
    logic [SB-1:0]        sat [3];
    logic [SAMPLE_W-1:0]  r_res [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc[k] = AW'(i_prod[k][0]) + AW'(i_prod[k][1]) + AW'(i_prod[k][2]);
            if (i_chroma_off && k > 0) begin
                acc[k] = acc[k] + HALF_OFF;
            end
            biased[k]  = acc[k] + RND;
            shifted[k] = biased[k][AW-1:FRAC+1];
            if (acc[k][AW-1]) begin
                sat[k] = '0;
            end else if (shifted[k] > MAXV_SH) begin
                sat[k] = {SB{1'b1}};
            end else begin
                sat[k] = shifted[k][SB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < 3; k++) begin
                r_res[k] <= SAMPLE_W'(sat[k]);
            end
        end
    end

    assign o_res = r_res;

endmodule

### sv/color_space_converter.sv
// Color space converter: one pixel per transfer, three components in and out.
// Input stream s_*: tdata = {comp_c, comp_b, comp_a}, 16 bits each, comp_a lowest.
// Output stream m_*: tdata = {res_c, res_b, res_a}, same packing.
// APB port: one register, conversion_mode at address 0 (bits 1:0), read back
// on prdata; pready is tied high. Change the mode only while no pixel is in
// flight.
// Pipeline: a pixel passes through the input register, the multiplier register
// and the round/clamp result register before it appears on m_tvalid.
// Throughput: one pixel per cycle without stalls; nine 18x18 multipliers work
// in parallel in a single stage, so every pixel passes once through the pipeline.
// Stall: each stage holds when the stage after it is full and not moving, so
// s_tready stays high while any stage still has a bubble; with m_tready low
// the block takes up to three pixels before s_tready drops. m_tdata holds
// until its transfer.
// Reset (synchronous, active low) empties the pipeline and sets the mode to
// RGB to YUV (MODE_RGB_YUV). Only the low SAMPLE_BITS of each component are used.
module color_space_converter import csc_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [3*SAMPLE_W-1:0]  s_tdata,   // comp_a, comp_b, comp_c
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [3*SAMPLE_W-1:0]  m_tdata,   // res_a, res_b, res_c
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + 2 + COEF_W;

    t_mode                r_mode;
    logic                 r_v1, r_v2, r_v3;
    logic [SB-1:0]        r_samp [3];
    t_mode                r_in_mode;
    logic                 adv1, adv2, adv3;
    logic signed [PW-1:0] prod [3][3];
    logic                 chroma_off;
    logic [SAMPLE_W-1:0]  res [3];

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODE) ? PDATA_W'(r_mode) : '0;

    assign adv3     = !r_v3 || m_tready;
    assign adv2     = !r_v2 || adv3;
    assign adv1     = !r_v1 || adv2;
    assign s_tready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RGB_YUV;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_MODE) begin
                r_mode <= t_mode'(pwdata[1:0]);
            end
            if (adv1) begin
                r_v1 <= s_tvalid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            for (int i = 0; i < 3; i++) begin
                r_samp[i] <= s_tdata[i*SAMPLE_W +: SB];
            end
            r_in_mode <= r_mode;
        end
    end

    csc_mult #(.SB(SB), .PW(PW)) u_mult (
        .i_clk        (i_clk),
        .i_load       (adv2),
        .i_mode       (r_in_mode),
        .i_samp       (r_samp),
        .o_prod       (prod),
        .o_chroma_off (chroma_off)
    );

    csc_round #(.SB(SB), .PW(PW)) u_round (
        .i_clk        (i_clk),
        .i_load       (adv3),
        .i_prod       (prod),
        .i_chroma_off (chroma_off),
        .o_res        (res)
    );

    assign m_tvalid = r_v3;
    assign m_tdata  = {res[2], res[1], res[0]};

endmodule

### sv/csc_checker.sv
`include "color_space_converter_assert.svh"

module csc_checker import csc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [3*SAMPLE_W-1:0] m_tdata,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [PADDR_W-1:0]    paddr,
    input logic [PDATA_W-1:0]    pwdata,
    input logic [PDATA_W-1:0]    prdata,
    input logic                  pready
);

    logic       stall_live;
    logic       wr_live;
    logic       rd_ok;
    logic [1:0] r_wr_mode;

    assign stall_live = i_rst_n && m_tvalid && !m_tready;
    assign wr_live    = i_rst_n && psel && penable && pwrite && pready && paddr == ADDR_MODE;
    assign rd_ok      = (paddr != ADDR_MODE) || (prdata == PDATA_W'(r_wr_mode));

    always_ff @(posedge i_clk) begin
        r_wr_mode <= pwdata[1:0];
    end

    `CSC_ASSERT_NXT(a_rst_empty, !i_rst_n, !m_tvalid, "output valid right after reset")
    `CSC_ASSERT_IMP(a_hold_valid, $past(stall_live), m_tvalid, "stalled result dropped")
    `CSC_ASSERT_IMP(a_hold_data, $past(stall_live), $stable(m_tdata), "stalled result changed")
    `CSC_ASSERT_IMP(a_mode_rdback, $past(wr_live), rd_ok, "mode readback mismatch")

endmodule

bind color_space_converter csc_checker u_csc_checker (.*);

### tb/tb_color_space_converter.sv
module tb_color_space_converter;
    import csc_pkg::*;

    localparam longint FULL_SCALE = 65535;
    localparam int     STALL_LIMIT = 1000;
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;

    // Q16 matrices, [mode][output row][input column]
    localparam int MATRIX [4][3][3] = '{
        '{ '{ 19595,  38470,   7471 },
           '{-11058, -21710,  32768 },
           '{ 32768, -27439,  -5329 } },
        '{ '{ 19595,  38470,   7471 },
           '{ 39059, -18022, -21037 },
           '{ 13894, -34275,  20382 } },
        '{ '{ 65536,      0,  91881 },
           '{ 65536, -22553, -46802 },
           '{ 65536, 116130,      0 } },
        '{ '{ 65536,  62652,  40698 },
           '{ 65536, -17826, -42402 },
           '{ 65536, -72483, 111608 } }
    };

    typedef struct packed {
        logic [15:0] comp_c;
        logic [15:0] comp_b;
        logic [15:0] comp_a;
    } t_pixel_in;

    typedef struct packed {
        logic [15:0] res_c;
        logic [15:0] res_b;
        logic [15:0] res_a;
    } t_pixel_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [3*SAMPLE_W-1:0] s_tdata;   // comp_a, comp_b, comp_c
    logic                 m_tvalid;
    logic                 m_tready;
    logic [3*SAMPLE_W-1:0] m_tdata;   // res_a, res_b, res_c
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    t_pixel_out pending_pixels[$];
    t_mode      cur_mode;
    int         fail_count;
    int         pixels_sent;
    int         pixels_checked;
    int         mode_writes;
    int         quiet_cycles;
    int         rx_stall_left;
    bit         tx_gaps_on;
    bit         rx_gaps_on;

    color_space_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_pixel_out convert_pixel(t_mode m, t_pixel_in px);
        longint     t [3];
        longint     acc;
        longint     r;
        logic [15:0] res [3];
        t_pixel_out out;
        t[0] = 2 * longint'(px.comp_a);
        t[1] = 2 * longint'(px.comp_b);
        t[2] = 2 * longint'(px.comp_c);
        // chroma inputs are centered at half scale
        if (m == MODE_YUV_RGB || m == MODE_YIQ_RGB) begin
            t[1] -= FULL_SCALE;
            t[2] -= FULL_SCALE;
        end
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                acc += longint'(MATRIX[m][k][i]) * t[i];
            if ((m == MODE_RGB_YUV || m == MODE_RGB_YIQ) && k > 0)
                acc += FULL_SCALE * 65536;
            if (acc < 0) begin
                r = 0;
            end else begin
                r = (acc + 65536) >>> 17;
                if (r > FULL_SCALE)
                    r = FULL_SCALE;
            end
            res[k] = r[15:0];
        end
        out.res_a = res[0];
        out.res_b = res[1];
        out.res_c = res[2];
        return out;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000 + 16'($urandom_range(0, 16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // output side: random stall bursts
    always @(negedge i_clk) begin
        if (rx_gaps_on && rx_stall_left > 0) begin
            m_tready = 1'b0;
            rx_stall_left--;
        end else if (rx_gaps_on && $urandom_range(0, 9) == 0) begin
            m_tready = 1'b0;
            rx_stall_left = $urandom_range(1, 18) - 1;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_pixel_out got;
        t_pixel_out want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_pixels.size() == 0) begin
                $error("result with no pixel pending: res_a %0d res_b %0d res_c %0d",
                       got.res_a, got.res_b, got.res_c);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("res_a", want.res_a, got.res_a);
                check_field("res_b", want.res_b, got.res_b);
                check_field("res_c", want.res_c, got.res_c);
                pixels_checked++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_pixel(t_pixel_in px);
        if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = px;
        do @(posedge i_clk); while (!s_tready);
        pending_pixels.push_back(convert_pixel(cur_mode, px));
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        t_pixel_in px;
        px.comp_a = rand_sample();
        px.comp_b = rand_sample();
        px.comp_c = rand_sample();
        send_pixel(px);
    endtask

    // stop sending and let the pipeline empty completely
    task automatic drain();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MODE) begin
            cur_mode = t_mode'(data[1:0]);
            mode_writes++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_mode_readback();
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = ADDR_MODE;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("conversion_mode", 16'(cur_mode), prdata[15:0]);
        if (prdata[PDATA_W-1:16] !== '0) begin
            $error("prdata upper bits: expected 0, got %0h", prdata[PDATA_W-1:16]);
            fail_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_mode(t_mode m);
        drain();
        // random upper bits must be dropped by the register
        apb_write(ADDR_MODE, {$urandom_range(0, 1) ? 30'($urandom) : 30'd0, m});
        check_mode_readback();
    endtask

    task automatic test_reset_mode();
        t_pixel_in px;
        check_mode_readback();
        px = '{comp_c: 16'd1000, comp_b: 16'd40000, comp_a: 16'd65535};
        send_pixel(px);
    endtask

    task automatic test_unused_address();
        set_mode(MODE_YIQ_RGB);
        apb_write(ADDR_UNUSED, 32'hFFFF_FFFE);
        check_mode_readback();
        send_random_pixel();
    endtask

    task automatic test_corner_pixels();
        t_pixel_in corners [6];
        corners[0] = '{comp_c: 16'h0000, comp_b: 16'h0000, comp_a: 16'h0000};
        corners[1] = '{comp_c: 16'hFFFF, comp_b: 16'hFFFF, comp_a: 16'hFFFF};
        corners[2] = '{comp_c: 16'h0000, comp_b: 16'h0000, comp_a: 16'hFFFF};
        corners[3] = '{comp_c: 16'h0000, comp_b: 16'hFFFF, comp_a: 16'h0000};
        corners[4] = '{comp_c: 16'hFFFF, comp_b: 16'h0000, comp_a: 16'h0000};
        corners[5] = '{comp_c: 16'h8000, comp_b: 16'h7FFF, comp_a: 16'h8000};
        for (int m = 3; m >= 0; m--) begin
            set_mode(t_mode'(m));
            foreach (corners[i])
                send_pixel(corners[i]);
        end
    endtask

    task automatic test_random_modes();
        t_mode m;
        for (int ph = 0; ph < 12; ph++) begin
            m = (ph < 4) ? t_mode'(ph) : t_mode'($urandom_range(0, 3));
            set_mode(m);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(110, 150)) send_random_pixel();
        end
    endtask

    // sender holds off mid-stream until the pipeline is empty
    task automatic test_pause_until_drained();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        repeat (30) send_random_pixel();
        drain();
        repeat (30) send_random_pixel();
    endtask

    task automatic test_back_to_back();
        set_mode(t_mode'($urandom_range(0, 3)));
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        repeat (100) send_random_pixel();
    endtask

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b1;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cur_mode = MODE_RGB_YUV;
        fail_count     = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        mode_writes    = 0;
        quiet_cycles   = 0;
        rx_stall_left  = 0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_mode();
        test_unused_address();
        test_corner_pixels();
        test_random_modes();
        test_pause_until_drained();
        test_back_to_back();

        drain();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d pixels, checked %0d results across %0d mode writes.",
                 pixels_sent, pixels_checked, mode_writes);
        $display("All four matrices, saturation corners, unused address and stalls on both sides.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/csc_pkg.sv
sv/csc_mult.sv
sv/csc_round.sv
sv/color_space_converter.sv
sv/csc_checker.sv
tb/tb_color_space_converter.sv
